// ===== src/bpdi_pkg.sv =====
// Package for the binary polynomial divstep iterator.
// Holds sizes, constants and the command/status structs shared by the design modules.
// No dependencies.
`timescale 1ns / 1ps

package bpdi_pkg;

	localparam int MAX_STEPS  = 64;
	localparam int POLY_WIDTH = 64;
	localparam int STEP_W     = $clog2(MAX_STEPS + 1);

	localparam int STEP_IN_W  = 7;
	localparam int DELTA_W    = 16;
	localparam int PORT_POLY_W = 64;

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 400;

	localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7fff;
	localparam logic [POLY_WIDTH-1:0] ONE_BIT = POLY_WIDTH'(1);

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} bpdi_cmd_t;

	typedef struct packed {
		logic done;
	} bpdi_status_t;

endpackage

// ===== src/bpdi_datapath.sv =====
// Datapath of the divstep iterator: working registers, step counter,
// one divstep per cycle and the output register. Depends on bpdi_pkg.
`timescale 1ns / 1ps

module bpdi_datapath import bpdi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bpdi_cmd_t                cmd,
	output bpdi_status_t             status,
	input  logic [IN_DATA_W-1:0]     in_data,
	output logic [OUT_DATA_W-1:0]    out_data
);

	logic [STEP_IN_W-1:0]        step_in;
	logic signed [DELTA_W-1:0]   delta_in;
	logic [POLY_WIDTH-1:0]       f_in;
	logic [POLY_WIDTH-1:0]       g_in;
	logic [STEP_W-1:0]           steps_clamped;

	logic [STEP_W-1:0]           count_q;
	logic signed [DELTA_W-1:0]   delta_q;
	logic [POLY_WIDTH-1:0]       f_q, g_q, u_q, v_q, q_q, r_q;

	logic                        swap;
	logic signed [DELTA_W-1:0]   delta_sw, delta_nx;
	logic [POLY_WIDTH-1:0]       f_sw, g_sw, u_sw, v_sw, q_sw, r_sw;
	logic [POLY_WIDTH-1:0]       f0_mask, g0_mask;
	logic [POLY_WIDTH-1:0]       g_nx, q_nx, r_nx, u_nx, v_nx;

	logic signed [DELTA_W-1:0]   delta_out_q;
	logic [POLY_WIDTH-1:0]       f_out_q, g_out_q, u_out_q, v_out_q, q_out_q, r_out_q;

	assign step_in  = in_data[STEP_IN_W-1:0];
	assign delta_in = in_data[STEP_IN_W +: DELTA_W];
	assign f_in     = in_data[STEP_IN_W + DELTA_W +: POLY_WIDTH];
	assign g_in     = in_data[STEP_IN_W + DELTA_W + PORT_POLY_W +: POLY_WIDTH];

	always_comb begin
		if (step_in > STEP_IN_W'(MAX_STEPS)) begin
			steps_clamped = STEP_W'(MAX_STEPS);
		end else begin
			steps_clamped = step_in[STEP_W-1:0];
		end
	end

	// Conditional swap first, then the elimination step on the swapped values.
	always_comb begin
		swap = (delta_q > 0) && g_q[0];
		if (swap) begin
			delta_sw = -delta_q;
			f_sw = g_q;
			g_sw = f_q;
			u_sw = q_q;
			q_sw = u_q;
			v_sw = r_q;
			r_sw = v_q;
		end else begin
			delta_sw = delta_q;
			f_sw = f_q;
			g_sw = g_q;
			u_sw = u_q;
			q_sw = q_q;
			v_sw = v_q;
			r_sw = r_q;
		end
		if (delta_sw < DELTA_MAX) begin
			delta_nx = delta_sw + 16'sd1;
		end else begin
			delta_nx = delta_sw;
		end
		f0_mask = {POLY_WIDTH{f_sw[0]}};
		g0_mask = {POLY_WIDTH{g_sw[0]}};
		g_nx = ((f0_mask & g_sw) ^ (g0_mask & f_sw)) >> 1;
		q_nx = (f0_mask & q_sw) ^ (g0_mask & u_sw);
		r_nx = (f0_mask & r_sw) ^ (g0_mask & v_sw);
		u_nx = u_sw << 1;
		v_nx = v_sw << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= steps_clamped;
		end else if (cmd.step) begin
			count_q <= count_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delta_q <= delta_in;
			f_q <= f_in;
			g_q <= g_in;
			u_q <= ONE_BIT;
			v_q <= '0;
			q_q <= '0;
			r_q <= ONE_BIT;
		end else if (cmd.step) begin
			delta_q <= delta_nx;
			f_q <= f_sw;
			g_q <= g_nx;
			u_q <= u_nx;
			v_q <= v_nx;
			q_q <= q_nx;
			r_q <= r_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			delta_out_q <= delta_q;
			f_out_q <= f_q;
			g_out_q <= g_q;
			u_out_q <= u_q;
			v_out_q <= v_q;
			q_out_q <= q_q;
			r_out_q <= r_q;
		end
	end

	assign status.done = (count_q == '0);

	assign out_data = {PORT_POLY_W'(r_out_q), PORT_POLY_W'(q_out_q),
		PORT_POLY_W'(v_out_q), PORT_POLY_W'(u_out_q),
		PORT_POLY_W'(g_out_q), PORT_POLY_W'(f_out_q), delta_out_q};

	step_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !status.done)
		else $error("divstep issued with no steps left");

endmodule

// ===== src/bpdi_ctrl.sv =====
// Controller of the divstep iterator: accepts an item, sequences the steps
// and hands the result to the output register. Depends on bpdi_pkg.
`timescale 1ns / 1ps

module bpdi_ctrl import bpdi_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  bpdi_status_t status,
	output bpdi_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.load    = in_valid && in_ready;
		cmd.step    = (state_q == ST_RUN) && !status.done;
		cmd.capture = (state_q == ST_RUN) && status.done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.capture) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN))
		else $error("accepted item did not start a run");

	run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && !status.done) |=> (state_q == ST_RUN))
		else $error("run left before all steps were done");

	capture_raises_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_valid_q)
		else $error("captured result not presented");

	no_load_and_capture: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.capture))
		else $error("load and capture in the same cycle");

endmodule

// ===== src/binary_poly_divstep_iterator.sv =====
// Top level of the binary polynomial divstep iterator.
// Channel    | dir | bits | transfer carries
// s_axis     | in  | 152  | step count, delta, f, g
// m_axis     | out | 400  | delta, f, g, u, v, q, r
// m_axis_tvalid rises after the input transfer once min(step_count, MAX_STEPS)
// divsteps have run, one divstep per cycle in the shared step unit after the
// load edge, and the result has been captured into the output register. The
// next input transfer can follow in the cycle after the capture.
// Reset clears the controller, the step counter and the output valid flag only.
// A result waiting on m_axis holds the finished run until the output
// register frees; a new item is accepted whenever no run is in progress.
// Depends on bpdi_pkg, bpdi_ctrl and bpdi_datapath.
`timescale 1ns / 1ps

module binary_poly_divstep_iterator import bpdi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// step_count[6:0], delta_in[22:7], f_in[86:23], g_in[150:87], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// delta_out[15:0], f_out[79:16], g_out[143:80], mat_u[207:144],
	// mat_v[271:208], mat_q[335:272], mat_r[399:336]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	bpdi_cmd_t    cmd;
	bpdi_status_t status;

	bpdi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	bpdi_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

endmodule

// ===== dv/binary_poly_divstep_iterator_tb.sv =====
// Self-checking testbench for binary_poly_divstep_iterator.
// A directed table and then random items go through s_axis; every m_axis transfer is
// compared field by field with a typed-in or in-bench model result. Depends on bpdi_pkg.
`timescale 1ns / 1ps

module binary_poly_divstep_iterator_tb;
	import bpdi_pkg::*;

	localparam int RANDOM_ITEMS = 930;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_REPORTS  = 10;
	localparam int DIR_ROWS     = 17;
	localparam logic [PORT_POLY_W-1:0] ALL_ONES = '1;
	localparam logic [PORT_POLY_W-1:0] POLY_MASK = ALL_ONES >> (PORT_POLY_W - POLY_WIDTH);

	// Member order matches the m_axis_tdata layout, last member in the lowest bits.
	typedef struct packed {
		logic [PORT_POLY_W-1:0]    r;
		logic [PORT_POLY_W-1:0]    q;
		logic [PORT_POLY_W-1:0]    v;
		logic [PORT_POLY_W-1:0]    u;
		logic [PORT_POLY_W-1:0]    g;
		logic [PORT_POLY_W-1:0]    f;
		logic signed [DELTA_W-1:0] delta;
	} divstep_result_t;

	typedef struct packed {
		logic [STEP_IN_W-1:0]      steps;
		logic signed [DELTA_W-1:0] delta;
		logic [PORT_POLY_W-1:0]    f;
		logic [PORT_POLY_W-1:0]    g;
		logic                      known;
		divstep_result_t           want;
	} divstep_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	divstep_result_t pending_results[$];
	int mismatch_count = 0;
	int sent_count = 0;
	int cycle_count = 0;

	// Rows with a typed-in result can be read off directly: zero steps give the
	// identity matrix, and all-zero polynomials only move delta, clear r and shift u out.
	divstep_row_t directed_rows [DIR_ROWS] = '{
		'{7'd0, 16'sh8000, ALL_ONES, ALL_ONES, 1'b1,
			'{r: 64'd1, q: 64'd0, v: 64'd0, u: 64'd1, g: ALL_ONES, f: ALL_ONES,
			delta: 16'sh8000}},
		'{7'd0, 16'sh7fff, 64'd0, 64'd0, 1'b1,
			'{r: 64'd1, q: 64'd0, v: 64'd0, u: 64'd1, g: 64'd0, f: 64'd0,
			delta: 16'sh7fff}},
		'{7'd1, 16'sh7fff, 64'd1, 64'd0, 1'b1,
			'{r: 64'd1, q: 64'd0, v: 64'd0, u: 64'd2, g: 64'd0, f: 64'd1,
			delta: 16'sh7fff}},
		'{7'd64, 16'sh8000, 64'd0, 64'd0, 1'b1,
			'{r: 64'd0, q: 64'd0, v: 64'd0, u: 64'd0, g: 64'd0, f: 64'd0,
			delta: 16'sh8040}},
		'{7'd127, 16'sh8000, 64'd0, 64'd0, 1'b1,
			'{r: 64'd0, q: 64'd0, v: 64'd0, u: 64'd0, g: 64'd0, f: 64'd0,
			delta: 16'sh8040}},
		'{7'd0, 16'sh5a5a, 64'h5555_aaaa_3333_cccc, 64'haaaa_5555_cccc_3333, 1'b1,
			'{r: 64'd1, q: 64'd0, v: 64'd0, u: 64'd1, g: 64'haaaa_5555_cccc_3333,
			f: 64'h5555_aaaa_3333_cccc, delta: 16'sh5a5a}},
		'{7'd64, 16'sh0000, 64'd1, ALL_ONES, 1'b0, '0},
		'{7'd64, 16'sh0001, ALL_ONES, ALL_ONES, 1'b0, '0},
		'{7'd1, 16'sh7fff, 64'd1, 64'd1, 1'b0, '0},
		'{7'd1, 16'sh0001, 64'd3, 64'd5, 1'b0, '0},
		'{7'd65, 16'shffff, 64'h0f0f_1234_5678_9abd, 64'hf0f0_fedc_ba98_7655, 1'b0, '0},
		'{7'd64, 16'sh7fff, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab, 1'b0, '0},
		'{7'd10, 16'sh0000, 64'h0000_0000_0000_0002, 64'h8000_0000_0000_0003, 1'b0, '0},
		'{7'd64, 16'sh8000, ALL_ONES, ALL_ONES, 1'b0, '0},
		'{7'd32, 16'sh7ffe, 64'hdead_beef_cafe_f00d, 64'h0123_4567_89ab_cdef, 1'b0, '0},
		'{7'd100, 16'sh0005, 64'h8000_0000_0000_0001, 64'hffff_ffff_ffff_fffe, 1'b0, '0},
		'{7'd63, 16'sh0002, 64'h1234_5678_9abc_def1, 64'hfedc_ba98_7654_3211, 1'b0, '0}
	};

	binary_poly_divstep_iterator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Runs the divsteps of one item and returns the final delta, f, g and matrix.
	function automatic divstep_result_t run_divsteps(logic [STEP_IN_W-1:0] steps_in,
			logic signed [DELTA_W-1:0] delta_in, logic [PORT_POLY_W-1:0] f_in,
			logic [PORT_POLY_W-1:0] g_in);
		int n;
		int d;
		logic [PORT_POLY_W-1:0] f, g, u, v, q, r, t, f_mask, g_mask;
		divstep_result_t res;
		n = (steps_in > MAX_STEPS) ? MAX_STEPS : int'(steps_in);
		d = int'(delta_in);
		f = f_in & POLY_MASK;
		g = g_in & POLY_MASK;
		u = PORT_POLY_W'(1);
		v = '0;
		q = '0;
		r = PORT_POLY_W'(1);
		for (int i = 0; i < n; i++) begin
			if (d > 0 && g[0]) begin
				d = -d;
				t = f; f = g; g = t;
				t = q; q = u; u = t;
				t = r; r = v; v = t;
			end
			if (d < int'(DELTA_MAX))
				d = d + 1;
			f_mask = {PORT_POLY_W{f[0]}};
			g_mask = {PORT_POLY_W{g[0]}};
			g = (((f_mask & g) ^ (g_mask & f)) >> 1) & POLY_MASK;
			q = ((f_mask & q) ^ (g_mask & u)) & POLY_MASK;
			r = ((f_mask & r) ^ (g_mask & v)) & POLY_MASK;
			u = (u << 1) & POLY_MASK;
			v = (v << 1) & POLY_MASK;
		end
		res.delta = d[DELTA_W-1:0];
		res.f = f;
		res.g = g;
		res.u = u;
		res.v = v;
		res.q = q;
		res.r = r;
		return res;
	endfunction

	// Items in this window go through with no idling on either side.
	function automatic bit quiet_window();
		return sent_count >= 400 && sent_count < 500;
	endfunction

	task automatic note_field(string name, logic [PORT_POLY_W-1:0] want,
			logic [PORT_POLY_W-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Offers one item, starting at a rising edge, and returns at the edge of its transfer.
	task automatic send_divstep(logic [STEP_IN_W-1:0] steps, logic signed [DELTA_W-1:0] delta,
			logic [PORT_POLY_W-1:0] f, logic [PORT_POLY_W-1:0] g, divstep_result_t want);
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (quiet_window() || pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else if (pick < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 80);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, g, f, delta, steps};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(want);
		sent_count++;
	endtask

	// Receiver: random short and long stalls, one long hold-off that fills the block.
	initial begin
		int stall_left;
		int pick;
		bit held_off;
		stall_left = 0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && sent_count >= 200) begin
				held_off = 1'b1;
				stall_left = 600;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (quiet_window()) begin
				m_axis_tready <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					m_axis_tready <= 1'b1;
				end else begin
					stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(19, 79);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		divstep_result_t got;
		divstep_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = divstep_result_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with nothing expected: %h", $realtime, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				note_field("delta_out", PORT_POLY_W'(want.delta), PORT_POLY_W'(got.delta));
				note_field("f_out", want.f, got.f);
				note_field("g_out", want.g, got.g);
				note_field("mat_u", want.u, got.u);
				note_field("mat_v", want.v, got.v);
				note_field("mat_q", want.q, got.q);
				note_field("mat_r", want.r, got.r);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [STEP_IN_W-1:0] steps;
		logic signed [DELTA_W-1:0] delta;
		logic [PORT_POLY_W-1:0] f, g;
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].known)
				send_divstep(directed_rows[i].steps, directed_rows[i].delta, directed_rows[i].f,
					directed_rows[i].g, directed_rows[i].want);
			else
				send_divstep(directed_rows[i].steps, directed_rows[i].delta, directed_rows[i].f,
					directed_rows[i].g, run_divsteps(directed_rows[i].steps,
					directed_rows[i].delta, directed_rows[i].f, directed_rows[i].g));
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Mostly legal step counts; some above the maximum to exercise clamping.
			pick = $urandom_range(0, 99);
			if (pick < 5)
				steps = STEP_IN_W'($urandom_range(65, 127));
			else if (pick < 10)
				steps = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd0;
			else
				steps = STEP_IN_W'($urandom_range(1, 64));

			// Deltas near the top can reach saturation within one run.
			pick = $urandom_range(0, 99);
			if (pick < 30)
				delta = DELTA_W'($urandom_range(0, 8) - 4);
			else if (pick < 40)
				delta = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
			else if (pick < 60)
				delta = DELTA_W'(16'sh7fff - $urandom_range(0, 70));
			else if (pick < 70)
				delta = DELTA_W'(16'sh8000 + $urandom_range(0, 70));
			else
				delta = DELTA_W'($urandom_range(0, 65535));

			f = {$urandom, $urandom};
			g = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				f = f & {$urandom, $urandom} & {$urandom, $urandom};
				g = g & {$urandom, $urandom} & {$urandom, $urandom};
			end else if (pick < 35) begin
				f[0] = 1'b1;
			end
			send_divstep(steps, delta, f, g, run_divsteps(steps, delta, f, g));
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * (MAX_STEPS + 2)) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
